### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bzf_pkg.sv
// Shared types, constants and width helpers for the Bezier segment fitter.
package bzf_pkg;

  localparam int COORD_W      = 16;
  localparam int MID_W        = 32;
  localparam int MAX_POINTS_D = 4096;
  localparam int COORD_BITS_D = 16;

  typedef struct packed {
    logic acc;
    logic take_last;
    logic mul1;
    logic mul2;
    logic sub;
    logic div_step;
    logic load_out;
  } bzf_cmd_t;

  typedef struct packed {
    logic short_seg;
    logic out_free;
  } bzf_stat_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [MID_W-1:0]   mid_x;
    logic [MID_W-1:0]   mid_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               too_many_points;
  } bzf_fit_t;

  function automatic int f_pw(input int coord_bits);
    return (coord_bits < COORD_W) ? coord_bits : COORD_W;
  endfunction

  function automatic int f_nw(input int max_points);
    return $clog2(max_points);
  endfunction

  function automatic int f_dw(input int max_points, input int coord_bits);
    return 2 * f_nw(max_points) + f_pw(coord_bits) + 11;
  endfunction

endpackage

### design/bzf_point_if.sv
// Point channel: one contour point per beat.
interface bzf_point_if;
  import bzf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic               last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

### design/bzf_fit_if.sv
// Fit channel: one set of Bezier control points per beat.
interface bzf_fit_if;
  import bzf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [MID_W-1:0]   mid_x;
  logic [MID_W-1:0]   mid_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic               too_many_points;

  modport source (output valid, output start_x, output start_y, output mid_x,
                  output mid_y, output end_x, output end_y, output too_many_points,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input mid_x,
                input mid_y, input end_x, input end_y, input too_many_points,
                output ready);
endinterface

### design/bzf_ctrl.sv
// Sequencer for point accumulation, fit arithmetic and result hand-off.
`include "assert_macros.svh"

module bzf_ctrl #(
  parameter int MAX_POINTS = bzf_pkg::MAX_POINTS_D,
  parameter int COORD_BITS = bzf_pkg::COORD_BITS_D
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              ready,
  input  bzf_pkg::bzf_stat_t stat,
  output bzf_pkg::bzf_cmd_t  cmd
);
  import bzf_pkg::*;

  localparam int DW  = f_dw(MAX_POINTS, COORD_BITS);
  localparam int DCW = $clog2(DW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [DCW-1:0] div_cnt;
  logic [DCW-1:0] div_cnt_next;

  assign ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    div_cnt_next = div_cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_last) begin
            cmd.take_last = 1'b1;
            state_next    = stat.short_seg ? ST_DONE : ST_MUL1;
          end else begin
            cmd.acc = 1'b1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub      = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DCW'(DW - 1)) begin
          state_next = ST_DONE;
        end else begin
          div_cnt_next = div_cnt + DCW'(1);
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  `ASSERT_NXT(done_exit_a, (state == ST_DONE) && stat.out_free, state == ST_IDLE, "done did not return to idle")
  `ASSERT_NXT(div_end_a, (state == ST_DIV) && (div_cnt == DCW'(DW - 1)), state == ST_DONE, "division overran")
  `ASSERT_NXT(long_go_a, ready && in_valid && in_last && !stat.short_seg, state == ST_MUL1, "long fit did not start")

endmodule

### design/bzf_dp.sv
// Accumulators, multipliers, serial dividers and output register of the fitter.
`include "assert_macros.svh"

module bzf_dp #(
  parameter int MAX_POINTS = bzf_pkg::MAX_POINTS_D,
  parameter int COORD_BITS = bzf_pkg::COORD_BITS_D
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bzf_pkg::bzf_cmd_t           cmd,
  output bzf_pkg::bzf_stat_t          stat,
  input  logic [bzf_pkg::COORD_W-1:0] point_x,
  input  logic [bzf_pkg::COORD_W-1:0] point_y,
  output bzf_pkg::bzf_fit_t           res,
  output logic                        res_valid,
  input  logic                        res_ready
);
  import bzf_pkg::*;

  localparam int PW   = f_pw(COORD_BITS);
  localparam int NW   = f_nw(MAX_POINTS);
  localparam int SW   = PW + NW;
  localparam int PRW  = NW + SW;
  localparam int UW   = 2 * NW + 1;
  localparam int DENW = 2 * NW + 1;
  localparam int MW   = 2 * NW + PW + 3;
  localparam int DW   = f_dw(MAX_POINTS, COORD_BITS);
  localparam int REMW = DENW + 1;
  localparam int TW   = (DW + 1 > 33) ? DW + 1 : 33;
  localparam logic [NW:0] MAX_L = (NW + 1)'(MAX_POINTS);

  logic                     seg_open;
  logic                     ovf;
  logic                     short_q;
  logic [NW-1:0]            cnt;
  logic [1:0][PW-1:0]       pt;
  logic [1:0][PW-1:0]       first;
  logic [1:0][PW-1:0]       last;
  logic [1:0][SW-1:0]       sum;
  logic [1:0][PRW-1:0]      prod;
  logic [1:0][PW:0]         psum;
  logic [UW-1:0]            ufac;
  logic [DENW-1:0]          den;
  logic [1:0][MW-1:0]       a_t;
  logic [1:0][MW-1:0]       b_t;
  logic [1:0]               neg;
  logic [1:0][DW-1:0]       dvd;
  logic [1:0][REMW-1:0]     rem;
  logic [1:0][REMW-1:0]     rsh;
  logic [1:0]               ge;
  logic [1:0][TW-1:0]       tot;
  logic [1:0][MID_W-1:0]    mid;
  logic [NW-1:0]            n_w;
  logic [2*NW-1:0]          nsq;
  logic                     room;

  assign pt[0] = point_x[PW-1:0];
  assign pt[1] = point_y[PW-1:0];
  assign n_w   = cnt + NW'(1);
  assign nsq   = {{NW{1'b0}}, n_w} * {{NW{1'b0}}, n_w};
  assign room  = (({1'b0, cnt} + (NW + 1)'(2)) < MAX_L);

  assign stat.short_seg = !seg_open || (cnt == '0);
  assign stat.out_free  = !res_valid || res_ready;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rsh[i] = {rem[i][REMW-2:0], dvd[i][DW-1]};
      ge[i]  = (rsh[i] >= {1'b0, den});
      tot[i] = TW'(dvd[i]) + TW'(rem[i] >= REMW'(den >> 1));
      if (short_q) begin
        mid[i] = MID_W'({({1'b0, first[i]} + {1'b0, last[i]}), 7'b0});
      end else if (neg[i]) begin
        mid[i] = (tot[i] > TW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                         : 32'd0 - tot[i][MID_W-1:0];
      end else begin
        mid[i] = (tot[i] > TW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : tot[i][MID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_open  <= 1'b0;
      ovf       <= 1'b0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (!seg_open) begin
          seg_open <= 1'b1;
          cnt      <= '0;
          ovf      <= 1'b0;
        end else if (room) begin
          cnt <= cnt + NW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        seg_open  <= 1'b0;
        ovf       <= 1'b0;
        cnt       <= '0;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (cmd.acc) begin
        if (!seg_open) begin
          first[i] <= pt[i];
          sum[i]   <= '0;
        end else if (room) begin
          sum[i] <= sum[i] + SW'(pt[i]);
        end
      end
      if (cmd.take_last) begin
        last[i] <= pt[i];
        if (!seg_open) begin
          first[i] <= pt[i];
        end
      end
      if (cmd.mul1) begin
        prod[i] <= {{SW{1'b0}}, n_w} * {{NW{1'b0}}, sum[i]};
        psum[i] <= {1'b0, first[i]} + {1'b0, last[i]};
      end
      if (cmd.mul2) begin
        a_t[i] <= MW'({prod[i], 2'b0}) + MW'({prod[i], 1'b0});
        b_t[i] <= MW'({{PW + 1{1'b0}}, ufac} * {{UW{1'b0}}, psum[i]});
      end
      if (cmd.sub) begin
        neg[i] <= (b_t[i] > a_t[i]);
        dvd[i] <= (b_t[i] > a_t[i]) ? {b_t[i] - a_t[i], 8'b0} : {a_t[i] - b_t[i], 8'b0};
        rem[i] <= '0;
      end
      if (cmd.div_step) begin
        rem[i] <= ge[i] ? rsh[i] - {1'b0, den} : rsh[i];
        dvd[i] <= {dvd[i][DW-2:0], ge[i]};
      end
    end
    if (cmd.take_last) begin
      short_q <= stat.short_seg;
    end
    if (cmd.mul1) begin
      ufac <= {{NW{1'b0}}, {n_w, 1'b0} - (NW + 1)'(1)} * {{NW + 1{1'b0}}, n_w - NW'(1)};
      den  <= {nsq - (2 * NW)'(1), 1'b0};
    end
    if (cmd.load_out) begin
      res.start_x         <= COORD_W'(first[0]);
      res.start_y         <= COORD_W'(first[1]);
      res.mid_x           <= mid[0];
      res.mid_y           <= mid[1];
      res.end_x           <= COORD_W'(last[0]);
      res.end_y           <= COORD_W'(last[1]);
      res.too_many_points <= ovf;
    end
  end

  `ASSERT_NXT(load_a, cmd.load_out, res_valid && !seg_open && (cnt == '0), "result load did not close segment")
  `ASSERT_IMP(closed_a, !seg_open, (cnt == '0) && !ovf, "closed segment holds stale count")
  `ASSERT_IMP(div_long_a, cmd.div_step, !short_q, "division ran for a short segment")

endmodule

### design/quadratic_bezier_segment_fit_top.sv
// Quadratic Bezier segment fitter: least-squares middle control point per contour segment.
// Channels: points (sink) takes one contour point per beat with point_x, point_y and
// last_point; fits (source) gives one beat per segment with start, mid and end control
// points and too_many_points. A beat moves when valid and ready are both high.
// Non-last points are taken one per cycle while idle, including while a result waits.
// A last point of a segment with two or more intervals runs two multiply steps, one
// subtract step and a bit-serial restoring division whose dividend is
// 2*clog2(MAX_POINTS)+PW+11 bits wide, PW being COORD_BITS capped at 16 (51 at the defaults),
// then the output load; points is not ready until the fit is loaded.
// Segments of one point or one interval skip the arithmetic and go straight to the
// output load.
// The division unit sets the cost per segment; x and y are divided in parallel.
// When fits stalls, the result holds in the output register; the next segment still
// accumulates, and after its last point the fit waits, with points not ready, until the
// register frees.
// Synchronous reset clears the open segment, the count and the output valid.
module quadratic_bezier_segment_fit_top #(
  parameter int MAX_POINTS = bzf_pkg::MAX_POINTS_D,
  parameter int COORD_BITS = bzf_pkg::COORD_BITS_D
) (
  input logic        clk,
  input logic        rst,
  bzf_point_if.sink  points,
  bzf_fit_if.source  fits
);
  import bzf_pkg::*;

  bzf_cmd_t  cmd;
  bzf_stat_t stat;
  bzf_fit_t  res;
  logic      res_valid;

  bzf_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_last  (points.last_point),
    .ready    (points.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bzf_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .point_x   (points.point_x),
    .point_y   (points.point_y),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (fits.ready)
  );

  assign fits.valid           = res_valid;
  assign fits.start_x         = res.start_x;
  assign fits.start_y         = res.start_y;
  assign fits.mid_x           = res.mid_x;
  assign fits.mid_y           = res.mid_y;
  assign fits.end_x           = res.end_x;
  assign fits.end_y           = res.end_y;
  assign fits.too_many_points = res.too_many_points;

endmodule

### dv/quadratic_bezier_segment_fit_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the Bezier segment fitter: table-driven and random segments against a predictor.
module quadratic_bezier_segment_fit_top_tb;
  import bzf_pkg::*;

  localparam int LIMIT = 400000;
  localparam int RAND_ITEMS = 620;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] CMASK = (32'd1 << COORD_BITS_D) - 32'd1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               typed;
    bzf_fit_t           fit;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bzf_point_if points_if();
  bzf_fit_if   fits_if();

  quadratic_bezier_segment_fit_top DUT (
    .clk    (clk),
    .rst    (rst),
    .points (points_if),
    .fits   (fits_if)
  );

  always #5 clk = ~clk;

  bzf_fit_t    pending_fits[$];
  point_row_t  table_rows[$];
  int          err_cnt = 0;
  int          fits_seen = 0;
  int          items_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  bit              seg_open = 1'b0;
  logic [15:0]     first_x = '0;
  logic [15:0]     first_y = '0;
  longint unsigned sum_x = 0;
  longint unsigned sum_y = 0;
  int unsigned     n_int = 0;
  bit              ovf = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  function automatic logic [31:0] mid_fixed(input longint unsigned n, input longint unsigned s,
                                            input longint unsigned p0, input longint unsigned pn);
    longint unsigned a, b, den, mag, q, r, frac, m;
    bit neg;
    a    = 6 * n * s;
    b    = (2 * n - 1) * (n - 1) * (p0 + pn);
    den  = 2 * (n * n - 1);
    neg  = b > a;
    mag  = neg ? b - a : a - b;
    q    = mag / den;
    r    = mag % den;
    frac = ((r << 8) + den / 2) / den;
    if (q >= (64'd1 << 40)) m = 64'd1 << 40;
    else m = (q << 8) + frac;
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return 32'(m);
  endfunction

  function automatic bit predict_fit(input logic [15:0] px_in, input logic [15:0] py_in,
                                     input logic last, output bzf_fit_t fit);
    logic [15:0] px, py;
    longint unsigned n;
    px  = px_in & CMASK[15:0];
    py  = py_in & CMASK[15:0];
    fit = '0;
    if (!last) begin
      if (!seg_open) begin
        seg_open = 1'b1;
        first_x  = px;
        first_y  = py;
        sum_x    = 0;
        sum_y    = 0;
        n_int    = 0;
        ovf      = 1'b0;
      end else if (n_int + 2 < MAX_POINTS_D) begin
        sum_x += px;
        sum_y += py;
        n_int++;
      end else begin
        ovf = 1'b1;
      end
      return 1'b0;
    end
    fit.end_x = px;
    fit.end_y = py;
    if (!seg_open) begin
      fit.start_x = px;
      fit.start_y = py;
      fit.mid_x   = {8'h00, px, 8'h00};
      fit.mid_y   = {8'h00, py, 8'h00};
    end else begin
      n = n_int + 1;
      fit.start_x = first_x;
      fit.start_y = first_y;
      if (n == 1) begin
        fit.mid_x = ({16'h0, first_x} + {16'h0, px}) << 7;
        fit.mid_y = ({16'h0, first_y} + {16'h0, py}) << 7;
      end else begin
        fit.mid_x = mid_fixed(n, sum_x, first_x, px);
        fit.mid_y = mid_fixed(n, sum_y, first_y, py);
      end
      fit.too_many_points = ovf;
    end
    seg_open = 1'b0;
    first_x  = '0;
    first_y  = '0;
    sum_x    = 0;
    sum_y    = 0;
    n_int    = 0;
    ovf      = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [15:0] x, input logic [15:0] y, input logic last);
    point_row_t r;
    r      = '0;
    r.x    = x;
    r.y    = y;
    r.last = last;
    table_rows.push_back(r);
  endfunction

  function automatic void add_typed(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] sx, input logic [15:0] sy,
                                    input logic [31:0] mx, input logic [31:0] my);
    point_row_t r;
    r             = '0;
    r.x           = x;
    r.y           = y;
    r.last        = 1'b1;
    r.typed       = 1'b1;
    r.fit.start_x = sx;
    r.fit.start_y = sy;
    r.fit.mid_x   = mx;
    r.fit.mid_y   = my;
    r.fit.end_x   = x;
    r.fit.end_y   = y;
    table_rows.push_back(r);
  endfunction

  function automatic logic [15:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(65535));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_point(input point_row_t r);
    bzf_fit_t fit;
    while (!calm && $urandom_range(99) < 34) begin
      points_if.valid = 1'b0;
      @(negedge clk);
    end
    points_if.valid      = 1'b1;
    points_if.point_x    = r.x;
    points_if.point_y    = r.y;
    points_if.last_point = r.last;
    do @(posedge clk); while (!points_if.ready);
    if (predict_fit(r.x, r.y, r.last, fit)) pending_fits.push_back(r.typed ? r.fit : fit);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_xy(input logic [15:0] x, input logic [15:0] y, input logic last);
    point_row_t r;
    r      = '0;
    r.x    = x;
    r.y    = y;
    r.last = last;
    send_point(r);
  endtask

  initial begin
    points_if.valid      = 1'b0;
    points_if.point_x    = '0;
    points_if.point_y    = '0;
    points_if.last_point = 1'b0;
    fits_if.ready        = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      fits_if.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && fits_seen >= 30) begin
      hold_done     = 1'b1;
      hold_left     = HOLD_CYCLES - 1;
      fits_if.ready = 1'b0;
    end else begin
      fits_if.ready = calm || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    bzf_fit_t want;
    if (!rst && fits_if.valid && fits_if.ready) begin
      fits_seen++;
      if (pending_fits.size() == 0) begin
        report_mismatch("unexpected fit beat", 0, 0);
      end else begin
        want = pending_fits.pop_front();
        if (fits_if.start_x !== want.start_x)
          report_mismatch("start_x", fits_if.start_x, want.start_x);
        if (fits_if.start_y !== want.start_y)
          report_mismatch("start_y", fits_if.start_y, want.start_y);
        if (fits_if.mid_x !== want.mid_x)
          report_mismatch("mid_x", fits_if.mid_x, want.mid_x);
        if (fits_if.mid_y !== want.mid_y)
          report_mismatch("mid_y", fits_if.mid_y, want.mid_y);
        if (fits_if.end_x !== want.end_x)
          report_mismatch("end_x", fits_if.end_x, want.end_x);
        if (fits_if.end_y !== want.end_y)
          report_mismatch("end_y", fits_if.end_y, want.end_y);
        if (fits_if.too_many_points !== want.too_many_points)
          report_mismatch("too_many_points", fits_if.too_many_points, want.too_many_points);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("quadratic_bezier_segment_fit_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int seg;
    int len;
    int pick;
    int start_cnt;
    int sizes[2];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_typed(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    add_typed(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h00FF_FF00, 32'h00FF_FF00);
    add_row(16'h0000, 16'h0000, 1'b0);
    add_typed(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 32'h007F_FF80, 32'h007F_FF80);
    add_row(16'hFFFF, 16'h0000, 1'b0);
    add_typed(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h007F_FF80, 32'h007F_FF80);
    add_row(16'hFFFF, 16'h0000, 1'b0);
    add_row(16'h0000, 16'hFFFF, 1'b0);
    add_typed(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 32'hFF00_0100, 32'h01FF_FE00);
    add_row(16'h0001, 16'h0000, 1'b0);
    add_row(16'h0000, 16'h0001, 1'b0);
    add_row(16'h0000, 16'h0000, 1'b1);
    add_row(16'hAAAA, 16'h5555, 1'b0);
    add_row(16'h5555, 16'hAAAA, 1'b0);
    add_row(16'hFFFF, 16'h0000, 1'b0);
    add_row(16'h0000, 16'hFFFF, 1'b0);
    add_row(16'h8001, 16'h7FFE, 1'b1);
    add_row(16'h0003, 16'h0005, 1'b0);
    add_row(16'h0007, 16'h0002, 1'b1);
    foreach (table_rows[i]) send_point(table_rows[i]);

    // one long segment, then a three-point one
    sizes[0] = 256;
    sizes[1] = 3;
    foreach (sizes[k])
      for (int i = 0; i < sizes[k]; i++) send_xy(rand_coord(), rand_coord(), i == sizes[k] - 1);

    seg = 0;
    start_cnt = items_sent;
    while (items_sent - start_cnt < RAND_ITEMS) begin
      calm = (seg >= 30) && (seg < 55);
      pick = $urandom_range(99);
      if (pick < 10) len = 1;
      else if (pick < 80) len = $urandom_range(12, 2);
      else len = $urandom_range(80, 13);
      for (int i = 0; i < len; i++) send_xy(rand_coord(), rand_coord(), i == len - 1);
      seg++;
    end
    calm = 1'b0;
    points_if.valid = 1'b0;

    while (pending_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_fits.size() == 0) begin
      $display("quadratic_bezier_segment_fit_top_tb OK");
    end else begin
      $display("quadratic_bezier_segment_fit_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### quadratic_bezier_segment_fit_top.f
+incdir+design
design/bzf_pkg.sv
design/bzf_point_if.sv
design/bzf_fit_if.sv
design/bzf_ctrl.sv
design/bzf_dp.sv
design/quadratic_bezier_segment_fit_top.sv
dv/quadratic_bezier_segment_fit_top_tb.sv
